[hdl/rmth_pkg.sv]
package rmth_pkg;

    localparam int CAPACITY    = 1024;
    localparam int LOWER_DEPTH = (CAPACITY + 1) / 2;
    localparam int UPPER_DEPTH = CAPACITY / 2;
    localparam int LA_W        = $clog2(LOWER_DEPTH);
    localparam int UA_W        = $clog2(UPPER_DEPTH);
    localparam int A_W         = (LA_W > UA_W) ? LA_W : UA_W;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int LC_W        = $clog2(LOWER_DEPTH + 1);
    localparam int UC_W        = $clog2(UPPER_DEPTH + 1);
    localparam int SAMPLE_W    = 32;
    localparam int MED_W       = 33;
    localparam int TOTAL_W     = 11;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [A_W-1:0]             t_addr;

    // Heap selector and order: lower heap is a max-heap, upper a min-heap.
    typedef enum logic {
        HEAP_LOWER = 1'b0,
        HEAP_UPPER = 1'b1
    } t_heap;

    // Command from the sequencer to a heap memory.
    typedef struct packed {
        logic    rd_en;
        t_addr   rd_addr;
        logic    wr_en;
        t_addr   wr_addr;
        t_sample wr_data;
    } t_mem_cmd;

    // Shared comparator: true when a goes before b in the given heap order.
    function automatic logic goes_before(t_sample a, t_sample b, t_heap h);
        logic r;
        r = (h == HEAP_LOWER) ? (a > b) : (a < b);
        return r;
    endfunction

endpackage

[hdl/rmth_ram.sv]
module rmth_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[hdl/rmth_seq.sv]
module rmth_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rmth_pkg::t_sample i_sample,
    output logic              o_busy,
    output logic              o_done,
    output logic signed [rmth_pkg::MED_W-1:0] o_med,
    output logic [rmth_pkg::TOTAL_W-1:0]      o_total,
    output logic              o_drop,
    output rmth_pkg::t_mem_cmd o_lcmd,
    output rmth_pkg::t_mem_cmd o_ucmd,
    input  rmth_pkg::t_sample i_lrd,
    input  rmth_pkg::t_sample i_urd
);
    import rmth_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DEC    = 10'b0000000010,
        S_PUSH_R = 10'b0000000100,
        S_PUSH_C = 10'b0000001000,
        S_DN_RL  = 10'b0000010000,
        S_DN_RR  = 10'b0000100000,
        S_DN_C   = 10'b0001000000,
        S_TOPS   = 10'b0010000000,
        S_TOPS_W = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    t_state r_state, n_state;
    logic [LC_W-1:0] r_lcnt, n_lcnt;
    logic [UC_W-1:0] r_ucnt, n_ucnt;
    t_sample r_s, n_s;          // value being sifted
    t_sample r_moved, n_moved;  // root moved to the other heap
    t_sample r_ltop, n_ltop;    // cached roots
    t_sample r_utop, n_utop;
    t_sample r_left, n_left;
    t_heap   r_heap, n_heap;
    logic    r_then_push, n_then_push;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;    // count of the heap being sifted
    logic    r_drop, n_drop;
    logic signed [MED_W-1:0] r_med, n_med;

    logic [CNT_W-1:0] total, parent, lchild;
    t_sample rd;
    t_mem_cmd cmd;

    always_comb begin
        total  = CNT_W'(r_lcnt) + CNT_W'(r_ucnt);
        parent = (r_idx - CNT_W'(1)) >> 1;
        lchild = (r_idx << 1) + CNT_W'(1);
        rd     = (r_heap == HEAP_LOWER) ? i_lrd : i_urd;
    end

    always_comb begin
        n_state = r_state; n_lcnt = r_lcnt; n_ucnt = r_ucnt; n_s = r_s;
        n_moved = r_moved; n_ltop = r_ltop; n_utop = r_utop; n_left = r_left;
        n_heap = r_heap; n_then_push = r_then_push; n_idx = r_idx;
        n_cnt = r_cnt; n_drop = r_drop; n_med = r_med;
        cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_s = i_sample;
                    n_drop = 1'b0;
                    n_then_push = 1'b0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (total >= CAP_C) begin
                    n_drop = 1'b1;
                    n_state = S_TOPS;
                end else if (r_ucnt != '0 && r_s > r_utop) begin
                    if (CNT_W'(r_lcnt) > CNT_W'(r_ucnt)) begin
                        n_heap = HEAP_UPPER; n_idx = CNT_W'(r_ucnt);
                        n_ucnt = r_ucnt + UC_W'(1);
                        n_state = S_PUSH_R;
                    end else begin
                        n_moved = r_utop; n_heap = HEAP_UPPER;
                        n_cnt = CNT_W'(r_ucnt); n_idx = '0;
                        n_then_push = 1'b1; n_state = S_DN_RL;
                    end
                end else if (CNT_W'(r_lcnt) == CNT_W'(r_ucnt)) begin
                    n_heap = HEAP_LOWER; n_idx = CNT_W'(r_lcnt);
                    n_lcnt = r_lcnt + LC_W'(1);
                    n_state = S_PUSH_R;
                end else if (r_s >= r_ltop) begin
                    n_heap = HEAP_UPPER; n_idx = CNT_W'(r_ucnt);
                    n_ucnt = r_ucnt + UC_W'(1);
                    n_state = S_PUSH_R;
                end else begin
                    n_moved = r_ltop; n_heap = HEAP_LOWER;
                    n_cnt = CNT_W'(r_lcnt); n_idx = '0;
                    n_then_push = 1'b1; n_state = S_DN_RL;
                end
            end
            // Sift up: read parent, then compare and move one level.
            S_PUSH_R: begin
                if (r_idx == '0) begin
                    cmd.wr_en = 1'b1; cmd.wr_addr = t_addr'(r_idx);
                    cmd.wr_data = r_s;
                    n_state = S_TOPS;
                end else begin
                    cmd.rd_en = 1'b1; cmd.rd_addr = t_addr'(parent);
                    n_state = S_PUSH_C;
                end
            end
            S_PUSH_C: begin
                cmd.wr_en = 1'b1; cmd.wr_addr = t_addr'(r_idx);
                if (goes_before(r_s, rd, r_heap)) begin
                    cmd.wr_data = rd;
                    n_idx = parent;
                    n_state = S_PUSH_R;
                end else begin
                    cmd.wr_data = r_s;
                    n_state = S_TOPS;
                end
            end
            // Sift down from the root: read left, read right, compare, move.
            S_DN_RL: begin
                if (lchild >= r_cnt) begin
                    cmd.wr_en = 1'b1; cmd.wr_addr = t_addr'(r_idx);
                    cmd.wr_data = r_s;
                    if (r_then_push) begin
                        n_then_push = 1'b0; n_s = r_moved;
                        if (r_heap == HEAP_UPPER) begin
                            n_heap = HEAP_LOWER; n_idx = CNT_W'(r_lcnt);
                            n_lcnt = r_lcnt + LC_W'(1);
                        end else begin
                            n_heap = HEAP_UPPER; n_idx = CNT_W'(r_ucnt);
                            n_ucnt = r_ucnt + UC_W'(1);
                        end
                        n_state = S_PUSH_R;
                    end else begin
                        n_state = S_TOPS;
                    end
                end else begin
                    cmd.rd_en = 1'b1; cmd.rd_addr = t_addr'(lchild);
                    n_state = S_DN_RR;
                end
            end
            S_DN_RR: begin
                n_left = rd;
                cmd.rd_en = 1'b1; cmd.rd_addr = t_addr'(lchild + CNT_W'(1));
                n_state = S_DN_C;
            end
            S_DN_C: begin
                logic    use_r;
                t_sample cv;
                use_r = ((lchild + CNT_W'(1)) < r_cnt) && goes_before(rd, r_left, r_heap);
                cv = use_r ? rd : r_left;
                if (goes_before(cv, r_s, r_heap)) begin
                    cmd.wr_en = 1'b1; cmd.wr_addr = t_addr'(r_idx); cmd.wr_data = cv;
                    n_idx = use_r ? lchild + CNT_W'(1) : lchild;
                end else begin
                    n_idx = r_cnt; // overridden below, where cnt=0 forces the finishing write at the next step
                end
                n_state = S_DN_RL;
                if (!goes_before(cv, r_s, r_heap)) begin
                    n_idx = r_idx;
                    n_cnt = '0;
                end
            end
            S_TOPS: begin
                cmd.rd_en = 1'b1; cmd.rd_addr = '0;
                n_state = S_TOPS_W;
            end
            S_TOPS_W: begin
                n_ltop = i_lrd; n_utop = i_urd;
                if (CNT_W'(r_lcnt) > CNT_W'(r_ucnt)) begin
                    n_med = MED_W'(i_lrd) + MED_W'(i_lrd);
                end else begin
                    n_med = MED_W'(i_lrd) + MED_W'(i_urd);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The sift-down finish uses cnt=0 to force the "no child" path.
    always_comb begin
        o_lcmd = '0;
        o_ucmd = '0;
        if (r_state == S_TOPS) begin
            o_lcmd = cmd;
            o_ucmd = cmd;
        end else if (r_heap == HEAP_LOWER) begin
            o_lcmd = cmd;
        end else begin
            o_ucmd = cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lcnt  <= '0;
            r_ucnt  <= '0;
        end else begin
            r_state <= n_state;
            r_lcnt  <= n_lcnt;
            r_ucnt  <= n_ucnt;
        end
        r_s <= n_s; r_moved <= n_moved; r_ltop <= n_ltop; r_utop <= n_utop;
        r_left <= n_left; r_heap <= n_heap; r_then_push <= n_then_push;
        r_idx <= n_idx; r_cnt <= n_cnt; r_drop <= n_drop; r_med <= n_med;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_DONE);
    assign o_med   = r_med;
    assign o_total = TOTAL_W'(total);
    assign o_drop  = r_drop;

endmodule

[hdl/running_median_two_heaps_core.sv]
// Channel | Direction | Handshake                         | Payload
// input   | in        | i_valid / o_ready                 | i_sample
// output  | out       | o_valid / i_ready                 | o_median_doubled, o_sample_count,
//         |           |                                   | o_full_drop
// Sift-down takes three steps a level (read left, read right, compare) and sift-up two
// (read parent, compare), besides a decide step and a read of both roots. The worst item
// is a root replace over nine levels followed by a push that climbs nine levels. A full drop
// skips to the root read. Reset clears the counts, the sequencer and the output valid only.
// o_ready is low while an item is in progress and while a result waits for i_ready.
module running_median_two_heaps_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [31:0]                i_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rmth_pkg::MED_W-1:0] o_median_doubled,
    output logic [rmth_pkg::TOTAL_W-1:0]      o_sample_count,
    output logic                              o_full_drop
);
    import rmth_pkg::*;

    t_mem_cmd lcmd, ucmd;
    t_sample  lrd, urd;
    logic     busy, done;
    logic signed [MED_W-1:0] med;
    logic [TOTAL_W-1:0] total;
    logic     drop;
    logic     r_ovalid;

    // A new item is refused while the sequencer is busy or a result waits to be taken.
    assign o_ready = !busy && !(r_ovalid && !i_ready);

    rmth_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_valid && o_ready), .i_sample(i_sample),
        .o_busy(busy), .o_done(done), .o_med(med), .o_total(total), .o_drop(drop),
        .o_lcmd(lcmd), .o_ucmd(ucmd), .i_lrd(lrd), .i_urd(urd)
    );

    rmth_ram #(.DEPTH(LOWER_DEPTH), .AW(A_W), .DW(SAMPLE_W)) u_lram (
        .i_clk(i_clk), .i_rd_en(lcmd.rd_en), .i_rd_addr(lcmd.rd_addr), .o_rd_data(lrd),
        .i_wr_en(lcmd.wr_en), .i_wr_addr(lcmd.wr_addr), .i_wr_data(lcmd.wr_data)
    );

    rmth_ram #(.DEPTH(UPPER_DEPTH), .AW(A_W), .DW(SAMPLE_W)) u_uram (
        .i_clk(i_clk), .i_rd_en(ucmd.rd_en), .i_rd_addr(ucmd.rd_addr), .o_rd_data(urd),
        .i_wr_en(ucmd.wr_en), .i_wr_addr(ucmd.wr_addr), .i_wr_data(ucmd.wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (done) begin
            o_median_doubled <= med;
            o_sample_count   <= total;
            o_full_drop      <= drop;
        end
    end

    assign o_valid = r_ovalid;

endmodule

[bench/tb_running_median_two_heaps_core.sv]
module tb_running_median_two_heaps_core;
    import rmth_pkg::*;

    localparam int IDLE_PCT     = 21;
    localparam int RANDOM_ITEMS = 1190;
    localparam int STALL_LIMIT  = 20000;
    localparam int MIX_VALS [15] = '{5, -3, 0, 0, 100, -100, 7, 6, 8, 1, 2, 3, 4, 50, -1};

    typedef logic signed [MED_W-1:0] t_med2;

    typedef struct {
        t_med2                median_doubled;
        logic [TOTAL_W-1:0]   sample_count;
        logic                 full_drop;
    } t_median_result;

    typedef struct {
        t_sample        sample;
        logic           has_known;
        t_median_result known;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_sample;
    logic               o_valid;
    logic               i_ready;
    t_med2              o_median_doubled;
    logic [TOTAL_W-1:0] o_sample_count;
    logic               o_full_drop;

    running_median_two_heaps_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_median_doubled (o_median_doubled),
        .o_sample_count   (o_sample_count),
        .o_full_drop      (o_full_drop)
    );

    // Predictor state: heaps of the lower and upper halves.
    t_sample lower_heap_m [LOWER_DEPTH];
    t_sample upper_heap_m [UPPER_DEPTH];
    int      lower_cnt_m;
    int      upper_cnt_m;

    t_median_result pending_medians[$];
    int             error_count;
    int             results_seen;
    int             drops_seen;
    int             stall_cycles;
    bit             no_idle;

    function automatic bit heap_first(t_sample a, t_sample b, t_heap h);
        return (h == HEAP_LOWER) ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(t_heap h, t_sample val);
        int i;
        int p;
        i = (h == HEAP_LOWER) ? lower_cnt_m : upper_cnt_m;
        if (h == HEAP_LOWER) lower_cnt_m++; else upper_cnt_m++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (h == HEAP_LOWER && heap_first(val, lower_heap_m[p], h)) begin
                lower_heap_m[i] = lower_heap_m[p];
                i = p;
            end else if (h == HEAP_UPPER && heap_first(val, upper_heap_m[p], h)) begin
                upper_heap_m[i] = upper_heap_m[p];
                i = p;
            end else begin
                break;
            end
        end
        if (h == HEAP_LOWER) lower_heap_m[i] = val; else upper_heap_m[i] = val;
    endtask

    // Swaps the top for val and lets val sink to its place.
    task automatic heap_swap_top(t_heap h, t_sample val);
        int i;
        int l;
        int c;
        int cnt;
        t_sample lc;
        t_sample rc;
        i = 0;
        cnt = (h == HEAP_LOWER) ? lower_cnt_m : upper_cnt_m;
        forever begin
            l = 2 * i + 1;
            if (l >= cnt) break;
            c = l;
            lc = (h == HEAP_LOWER) ? lower_heap_m[l] : upper_heap_m[l];
            if (l + 1 < cnt) begin
                rc = (h == HEAP_LOWER) ? lower_heap_m[l+1] : upper_heap_m[l+1];
                if (heap_first(rc, lc, h)) begin
                    c = l + 1;
                    lc = rc;
                end
            end
            if (!heap_first(lc, val, h)) break;
            if (h == HEAP_LOWER) lower_heap_m[i] = lc; else upper_heap_m[i] = lc;
            i = c;
        end
        if (h == HEAP_LOWER) lower_heap_m[i] = val; else upper_heap_m[i] = val;
    endtask

    task automatic predict_median(t_sample s, output t_median_result r);
        t_sample moved;
        r.full_drop = 1'b0;
        if (lower_cnt_m + upper_cnt_m >= CAPACITY) begin
            r.full_drop = 1'b1;
        end else if (upper_cnt_m > 0 && s > upper_heap_m[0]) begin
            if (lower_cnt_m > upper_cnt_m) begin
                heap_insert(HEAP_UPPER, s);
            end else begin
                moved = upper_heap_m[0];
                heap_swap_top(HEAP_UPPER, s);
                heap_insert(HEAP_LOWER, moved);
            end
        end else if (lower_cnt_m == upper_cnt_m) begin
            heap_insert(HEAP_LOWER, s);
        end else if (s >= lower_heap_m[0]) begin
            heap_insert(HEAP_UPPER, s);
        end else begin
            moved = lower_heap_m[0];
            heap_swap_top(HEAP_LOWER, s);
            heap_insert(HEAP_UPPER, moved);
        end
        if (lower_cnt_m > upper_cnt_m)
            r.median_doubled = t_med2'(lower_heap_m[0]) + t_med2'(lower_heap_m[0]);
        else
            r.median_doubled = t_med2'(lower_heap_m[0]) + t_med2'(upper_heap_m[0]);
        r.sample_count = TOTAL_W'(lower_cnt_m + upper_cnt_m);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    bit idle_roll;
    always @(negedge i_clk) begin
        idle_roll = no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        i_ready <= !idle_roll;
    end

    // Output checker and watchdog.
    always @(posedge i_clk) begin
        t_median_result want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (o_full_drop) drops_seen++;
                if (pending_medians.size() == 0) begin
                    report_mismatch("unexpected result, sample_count", o_sample_count, 0);
                end else begin
                    want = pending_medians.pop_front();
                    if (o_median_doubled !== want.median_doubled)
                        report_mismatch("median_doubled", o_median_doubled,
                                        want.median_doubled);
                    if (o_sample_count !== want.sample_count)
                        report_mismatch("sample_count", o_sample_count, want.sample_count);
                    if (o_full_drop !== want.full_drop)
                        report_mismatch("full_drop", o_full_drop, want.full_drop);
                end
            end
        end
    end

    // Valid drops only while the sender idles, so back-to-back transfers keep it high.
    task automatic send_sample(t_sample s, bit has_known, t_median_result known);
        t_median_result r;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        predict_median(s, r);
        if (has_known && (r.median_doubled !== known.median_doubled ||
                          r.sample_count !== known.sample_count ||
                          r.full_drop !== known.full_drop))
            report_mismatch("table row vs predictor, sample", s, r.median_doubled);
        pending_medians = {pending_medians, r};
        @(negedge i_clk);
    endtask

    function automatic t_sample rand_sample(int mode);
        case (mode)
            0: return t_sample'($urandom);
            1: return t_sample'($urandom_range(40)) - 20;
            default: return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(3)
                                             : 32'sh80000000 + $urandom_range(3);
        endcase
    endfunction

    t_stim_row table_rows[$];

    function automatic t_stim_row row(t_sample s, bit k, t_med2 m, int c, bit d);
        t_stim_row x;
        x.sample = s;
        x.has_known = k;
        x.known.median_doubled = m;
        x.known.sample_count = TOTAL_W'(c);
        x.known.full_drop = d;
        return x;
    endfunction

    initial begin
        t_median_result none;
        int fill;
        int burst;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_ready = 1'b0;
        no_idle = 1'b0;
        error_count = 0;
        results_seen = 0;
        drops_seen = 0;
        stall_cycles = 0;
        lower_cnt_m = 0;
        upper_cnt_m = 0;
        none = '{default: '0};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes first, then ties and both rebalancing directions.
        table_rows = {
            row(32'sh7FFFFFFF, 1, 33'sh0FFFFFFFE, 1, 0),
            row(32'sh7FFFFFFF, 1, 33'sh0FFFFFFFE, 2, 0),
            row(32'sh7FFFFFFF, 1, 33'sh0FFFFFFFE, 3, 0),
            row(32'sh80000000, 1, 33'sh0FFFFFFFE, 4, 0),
            row(32'sh80000000, 1, 33'sh0FFFFFFFE, 5, 0),
            row(32'sh80000000, 1, -33'sh1, 6, 0),
            row(32'sh80000000, 1, -33'sh100000000, 7, 0),
            row(32'sh80000000, 1, -33'sh100000000, 8, 0)
        };
        foreach (MIX_VALS[i])
            table_rows = {table_rows, row(t_sample'(MIX_VALS[i]), 0, '0, 0, 0)};
        foreach (table_rows[i])
            send_sample(table_rows[i].sample, table_rows[i].has_known,
                        table_rows[i].known);

        // Random part, with a burst that never idles.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 400 && n < 600);
            send_sample(rand_sample($urandom_range(9) < 6 ? 0 :
                                    ($urandom_range(1) ? 1 : 2)), 0, none);
        end
        no_idle = 1'b0;
        // Drive the heaps to capacity, then prove samples are dropped.
        fill = CAPACITY - (lower_cnt_m + upper_cnt_m);
        for (int n = 0; n < fill + 40; n++)
            send_sample(rand_sample($urandom_range(2)), 0, none);
        i_valid <= 1'b0;

        burst = 0;
        while (pending_medians.size() != 0 && burst < STALL_LIMIT) begin
            @(posedge i_clk);
            burst++;
        end
        repeat (60) @(posedge i_clk);
        $display("Covered %0d results, %0d of them dropped at full capacity,",
                 results_seen, drops_seen);
        $display("with extreme samples, ties and random stalls on both channels.");
        if (error_count == 0 && pending_medians.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
